[rtl/apf_pkg.sv]
// ----------------------------------------------------------------------------
// apf_pkg: shared types and constants of the articulation point finder
// Sizes of the vertex, edge and time spaces and the search sequencer states.
// ----------------------------------------------------------------------------
package apf_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int VW = $clog2(MAX_VERTICES);       // vertex index width
   localparam int EW = $clog2(MAX_EDGES);          // edge index width
   localparam int CW = EW + 1;                     // edge count width
   localparam int TW = $clog2(MAX_VERTICES + 2);   // discovery time width
   localparam int NW = VW + 1;                     // vertex count width

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_RUN = 1'b1;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_CLEAR  = 12'b000000000010,
      ST_ROOT   = 12'b000000000100,
      ST_TOP    = 12'b000000001000,
      ST_EREAD  = 12'b000000010000,
      ST_EDGE   = 12'b000000100000,
      ST_BACK   = 12'b000001000000,
      ST_POP    = 12'b000010000000,
      ST_POP2   = 12'b000100000000,
      ST_REPORT = 12'b001000000000,
      ST_EMIT   = 12'b010000000000,
      ST_NONE   = 12'b100000000000
   } state_type;

   // one stack frame of the search
   typedef struct packed {
      logic [VW-1:0] vtx;
      logic [VW-1:0] parent;
      logic          has_parent;
      logic [CW-1:0] pos;
      logic [1:0]    children;   // saturates at 2
   } frame_type;

   // result word handed from the sequencer to the output stage
   typedef struct packed {
      logic          found;
      logic [VW-1:0] vertex;
      logic          last;
      logic          dropped;
   } result_type;

endpackage

[rtl/apf_edge_ram.sv]
// ----------------------------------------------------------------------------
// apf_edge_ram: edge store
// One write port and one registered read port holding endpoint pairs.
// ----------------------------------------------------------------------------
module apf_edge_ram
   import apf_pkg::*;
(
   input  logic          clock,
   input  logic          wr_en,
   input  logic [EW-1:0] wr_addr,
   input  logic [VW-1:0] wr_a,
   input  logic [VW-1:0] wr_b,
   input  logic [EW-1:0] rd_addr,
   output logic [VW-1:0] rd_a,
   output logic [VW-1:0] rd_b
);

   logic [2*VW-1:0] mem [MAX_EDGES];
   logic [2*VW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_a, wr_b};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_a = rd_ff[2*VW-1:VW];
   assign rd_b = rd_ff[VW-1:0];

endmodule

[rtl/apf_output_reg.sv]
// ----------------------------------------------------------------------------
// apf_output_reg: result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module apf_output_reg
   import apf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_word,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_word
);

   logic       valid_ff, valid_in;
   result_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign full      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

[rtl/articulation_point_finder_top.sv]
// run: every stored edge is read for each visited vertex, plus a root scan, pop
//   and report scan per vertex and one result word per cut vertex; an output
//   stall holds the result words
// throughput: one add word per cycle while idle; the stored edge and vertex counts set the run length
// reset: synchronous, clears the edge count, drop flag, vertex count (to 64) and sequencer
// ----------------------------------------------------------------------------
// articulation_point_finder_top: articulation points by depth-first search
// Stores edges, then walks them with an explicit stack and reports cut vertices.
// ----------------------------------------------------------------------------
module articulation_point_finder_top
   import apf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [6:0]    csr_vertex_count,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_action,
   input  logic [5:0]    req_edge_from,
   input  logic [5:0]    req_edge_to,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_found,
   output logic [5:0]    rsp_vertex,
   output logic          rsp_last,
   output logic          rsp_edges_dropped
);

   state_type state_ff, state_in;
   logic [6:0]    vcount_ff;
   logic [CW-1:0] etotal_ff, etotal_in;
   logic          drop_ff, drop_in;
   logic [NW-1:0] n_eff;

   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] cut_ff, cut_in;
   logic [TW-1:0] disc_ff [MAX_VERTICES];
   logic [TW-1:0] low_ff  [MAX_VERTICES];
   frame_type     stack_ff [MAX_VERTICES];
   logic [NW-1:0] sp_ff, sp_in;
   logic [TW-1:0] time_ff, time_in;
   logic [NW-1:0] vidx_ff, vidx_in;
   logic          any_ff, any_in;
   frame_type     top_ff, top_in;     // working copy of the top frame
   frame_type     ptop_ff, ptop_in;   // parent frame during a pop

   logic          disc_we, low_we, stk_we;
   logic [VW-1:0] disc_addr, low_addr, stk_addr;
   logic [TW-1:0] disc_val, low_val;
   frame_type     stk_val;

   // registered read ports of the time, low and stack stores
   logic [TW-1:0] disc_rd_ff, low_rd0_ff, low_rd1_ff;
   frame_type     stk_rd_ff;
   logic [VW-1:0] disc_raddr;

   logic          ram_we;
   logic [VW-1:0] ram_a, ram_b;
   logic [VW-1:0] nb;
   logic          nb_ok;

   logic          out_load, out_full;
   result_type    out_word, rsp_word;
   logic          req_take;

   assign n_eff = (vcount_ff == 7'd0) ? NW'(1) :
                  (vcount_ff > 7'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vcount_ff[NW-1:0];

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign ram_we    = req_take && req_action == ACT_ADD && etotal_ff < CW'(MAX_EDGES)
                      && NW'(req_edge_from) < n_eff && NW'(req_edge_to) < n_eff;

   apf_edge_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (etotal_ff[EW-1:0]),
      .wr_a    (req_edge_from),
      .wr_b    (req_edge_to),
      .rd_addr (top_ff.pos[EW-1:0]),
      .rd_a    (ram_a),
      .rd_b    (ram_b)
   );

   // neighbor of the top vertex on the edge just read, if any
   always_comb begin
      nb    = ram_a;
      nb_ok = 1'b0;
      if (NW'(ram_a) < n_eff && NW'(ram_b) < n_eff) begin
         if (ram_a == top_ff.vtx) begin
            nb = ram_b; nb_ok = 1'b1;
         end else if (ram_b == top_ff.vtx) begin
            nb = ram_a; nb_ok = 1'b1;
         end
      end
   end

   // neighbor time is fetched during the edge read, parent time during the pop
   assign disc_raddr = (state_ff == ST_POP) ? stk_rd_ff.vtx : nb;

   always_comb begin
      state_in   = state_ff;
      etotal_in  = etotal_ff;
      drop_in    = drop_ff;
      visited_in = visited_ff;
      cut_in     = cut_ff;
      sp_in      = sp_ff;
      time_in    = time_ff;
      vidx_in    = vidx_ff;
      any_in     = any_ff;
      top_in     = top_ff;
      ptop_in    = ptop_ff;
      disc_we = 1'b0; disc_addr = top_ff.vtx; disc_val = time_ff;
      low_we  = 1'b0; low_addr  = top_ff.vtx; low_val  = time_ff;
      stk_we  = 1'b0; stk_addr  = sp_ff[VW-1:0]; stk_val = top_ff;
      out_load = 1'b0;
      out_word = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_ADD) begin
                  if (ram_we) etotal_in = etotal_ff + CW'(1);
                  else        drop_in   = 1'b1;
               end else begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            visited_in = '0;
            cut_in     = '0;
            time_in    = TW'(1);
            vidx_in    = '0;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            // pick next unvisited root, or finish
            if (vidx_ff >= n_eff) begin
               vidx_in  = '0;
               any_in   = 1'b0;
               state_in = ST_REPORT;
            end else if (visited_ff[vidx_ff[VW-1:0]]) begin
               vidx_in = vidx_ff + NW'(1);
            end else begin
               visited_in[vidx_ff[VW-1:0]] = 1'b1;
               disc_we = 1'b1; disc_addr = vidx_ff[VW-1:0];
               low_we  = 1'b1; low_addr  = vidx_ff[VW-1:0];
               time_in = time_ff + TW'(1);
               top_in  = '{vtx: vidx_ff[VW-1:0], parent: '0, has_parent: 1'b0,
                           pos: '0, children: 2'd0};
               sp_in   = NW'(1);
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            if (top_ff.pos < etotal_ff) begin
               state_in = ST_EREAD;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_EREAD: begin
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            top_in.pos = top_ff.pos + CW'(1);
            state_in   = ST_TOP;
            if (nb_ok && !(top_ff.has_parent && nb == top_ff.parent)) begin
               if (!visited_ff[nb]) begin
                  // push: save current frame and open the child
                  stk_we = 1'b1; stk_addr = sp_ff[VW-1:0] - VW'(1);
                  stk_val = top_ff; stk_val.pos = top_ff.pos + CW'(1);
                  visited_in[nb] = 1'b1;
                  disc_we = 1'b1; disc_addr = nb;
                  low_we  = 1'b1; low_addr  = nb;
                  time_in = time_ff + TW'(1);
                  top_in  = '{vtx: nb, parent: top_ff.vtx, has_parent: 1'b1,
                              pos: '0, children: 2'd0};
                  sp_in   = sp_ff + NW'(1);
               end else if (disc_rd_ff < low_rd0_ff) begin
                  low_we = 1'b1; low_val = disc_rd_ff;
               end
            end
         end
         ST_POP: begin
            if (top_ff.has_parent) begin
               ptop_in  = stk_rd_ff;
               state_in = ST_POP2;
            end else begin
               if (top_ff.children == 2'd2) cut_in[top_ff.vtx] = 1'b1;
               vidx_in  = vidx_ff + NW'(1);
               sp_in    = '0;
               state_in = ST_ROOT;
            end
         end
         ST_POP2: begin
            if (low_rd0_ff < low_rd1_ff) begin
               low_we = 1'b1; low_addr = ptop_ff.vtx; low_val = low_rd0_ff;
            end
            if (low_rd0_ff >= disc_rd_ff && ptop_ff.has_parent) begin
               cut_in[ptop_ff.vtx] = 1'b1;
            end
            top_in = ptop_ff;
            if (ptop_ff.children != 2'd2) top_in.children = ptop_ff.children + 2'd1;
            sp_in    = sp_ff - NW'(1);
            state_in = ST_TOP;
         end
         ST_REPORT: begin
            // scan cut marks; one result per marked vertex
            if (vidx_ff >= n_eff) begin
               state_in = any_ff ? ST_IDLE : ST_NONE;
               if (any_ff) begin
                  etotal_in = '0;
                  drop_in   = 1'b0;
               end
            end else if (cut_ff[vidx_ff[VW-1:0]]) begin
               state_in = ST_EMIT;
            end else begin
               vidx_in = vidx_ff + NW'(1);
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               logic more;
               more = 1'b0;
               for (int i = 0; i < MAX_VERTICES; i++) begin
                  if (NW'(i) > vidx_ff && NW'(i) < n_eff && cut_ff[i]) more = 1'b1;
               end
               out_load = 1'b1;
               out_word = '{found: 1'b1, vertex: vidx_ff[VW-1:0], last: !more,
                            dropped: drop_ff};
               any_in   = 1'b1;
               vidx_in  = vidx_ff + NW'(1);
               state_in = ST_REPORT;
            end
         end
         ST_NONE: begin
            if (!out_full) begin
               out_load  = 1'b1;
               out_word  = '{found: 1'b0, vertex: '0, last: 1'b1, dropped: drop_ff};
               etotal_in = '0;
               drop_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= 7'(MAX_VERTICES);
         etotal_ff <= '0;
         drop_ff   <= 1'b0;
         sp_ff     <= '0;
         time_ff   <= TW'(1);
      end else begin
         state_ff  <= state_in;
         etotal_ff <= etotal_in;
         drop_ff   <= drop_in;
         sp_ff     <= sp_in;
         time_ff   <= time_in;
         if (csr_valid && csr_ready) vcount_ff <= csr_vertex_count;
      end
      visited_ff <= visited_in;
      cut_ff     <= cut_in;
      vidx_ff    <= vidx_in;
      any_ff     <= any_in;
      top_ff     <= top_in;
      ptop_ff    <= ptop_in;
      if (disc_we) disc_ff[disc_addr] <= disc_val;
      if (low_we)  low_ff[low_addr]   <= low_val;
      if (stk_we)  stack_ff[stk_addr] <= stk_val;
      disc_rd_ff <= disc_ff[disc_raddr];
      low_rd0_ff <= low_ff[top_ff.vtx];
      low_rd1_ff <= low_ff[stk_rd_ff.vtx];
      stk_rd_ff  <= stack_ff[sp_ff[VW-1:0] - VW'(2)];
   end

   apf_output_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_word (out_word),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_found         = rsp_word.found;
   assign rsp_vertex        = rsp_word.vertex;
   assign rsp_last          = rsp_word.last;
   assign rsp_edges_dropped = rsp_word.dropped;

endmodule

[rtl/apf_checker.sv]
// ----------------------------------------------------------------------------
// apf_checker: port checks of the articulation point finder
// Watches the handshakes and result words at the top level ports.
// ----------------------------------------------------------------------------
module apf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_found,
   input logic [5:0] rsp_vertex,
   input logic       rsp_last
);

   // a held word keeps its vertex and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex) && $stable(rsp_last))
      else $error("stalled result word changed");

   // a no-result word is always the final one
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_vertex == 6'd0)
      else $error("empty result not marked last");

   // after a run is taken the block stalls input
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action |=> req_stall)
      else $error("input taken during a run");

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind articulation_point_finder_top apf_checker u_apf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_action (req_action),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_found  (rsp_found),
   .rsp_vertex (rsp_vertex),
   .rsp_last   (rsp_last)
);
